/* hdl/crss_pkg.sv */
package crss_pkg;

  localparam int LenW      = 16;
  localparam int ConfW     = 16;
  localparam int CountOutW = 4;

  localparam logic [ConfW-1:0] ConfOne = 16'hFFFF;

  typedef struct packed {
    logic [LenW-1:0]  new_length;
    logic [ConfW-1:0] new_confidence;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [LenW-1:0]      mean_length;
    logic [ConfW-1:0]     low_conf;
    logic [CountOutW-1:0] sample_count;
  } out_item_t;

endpackage

/* hdl/confidence_ranked_sample_store.sv */
// channel  | ports                             | direction
// ---------+-----------------------------------+----------
// input    | in_valid, in_ready, in_data       | in
// result   | out_valid, out_ready, out_data    | out
//
// a stored item gives its result after one read pass over the store, then a
// restoring divider that yields one quotient bit per cycle; a rejected item goes
// straight to the done state, which writes its result once the output register is free.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next item is taken while it is still held.
// rst_n is synchronous: count, mean and minimum clear to zero, store is not cleared.
module confidence_ranked_sample_store #(
  parameter int DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crss_pkg::out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = crss_pkg::LenW + CW;
  localparam int DW = $clog2(SW + 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);
  localparam logic [DW-1:0] DivLast = DW'(SW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_DIV,
    ST_DONE
  } state_t;

  // store
  logic [crss_pkg::LenW-1:0]  len_mem  [DEPTH];
  logic [crss_pkg::ConfW-1:0] conf_mem [DEPTH];
  logic [crss_pkg::LenW-1:0]  rd_len_r;
  logic [crss_pkg::ConfW-1:0] rd_conf_r;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [crss_pkg::LenW-1:0]  mean_r, mean_nxt;
  logic [crss_pkg::ConfW-1:0] lowest_r, lowest_nxt;
  logic [crss_pkg::LenW-1:0]  len_r, len_nxt;
  logic [crss_pkg::ConfW-1:0] conf_r, conf_nxt;
  logic                       acc_r, acc_nxt;
  logic                       repl_r, repl_nxt;
  logic                       found_r, found_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]              rd_idx_r, rd_idx_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic [crss_pkg::ConfW-1:0] min_r, min_nxt;
  logic [CW-1:0]              rem_r, rem_nxt;
  logic [DW-1:0]              div_cnt_r, div_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  crss_pkg::out_item_t        out_r, out_nxt;

  logic                       issue;
  logic                       hit;
  logic [crss_pkg::LenW-1:0]  eff_len;
  logic [crss_pkg::ConfW-1:0] eff_conf;
  logic [CW:0]                trial;
  logic [CW:0]                diff;
  logic                       qbit;
  logic [SW-1:0]              q_step;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [crss_pkg::LenW-1:0]  wr_len;
  logic [crss_pkg::ConfW-1:0] wr_conf;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pass over stored entries, the first tie at the minimum takes the new item
  assign issue    = (state_r == ST_PASS) && (idx_r < fill_r);
  assign hit      = rd_vld_r && repl_r && !found_r && (rd_conf_r == lowest_r);
  assign eff_len  = hit ? len_r : rd_len_r;
  assign eff_conf = hit ? conf_r : rd_conf_r;

  // restoring divide step, sum_r doubles as the quotient shift register
  assign trial  = {rem_r, sum_r[SW-1]};
  assign diff   = trial - {1'b0, fill_r};
  assign qbit   = (trial >= {1'b0, fill_r});
  assign q_step = {sum_r[SW-2:0], qbit};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r[AW-1:0];
    wr_len  = in_data.new_length;
    wr_conf = in_data.new_confidence;
    if (hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r;
      wr_len  = len_r;
      wr_conf = conf_r;
    end else if ((state_r == ST_IDLE) && in_valid && (fill_r < DepthC)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[wr_addr]  <= wr_len;
      conf_mem[wr_addr] <= wr_conf;
    end
    rd_len_r  <= len_mem[idx_r[AW-1:0]];
    rd_conf_r <= conf_mem[idx_r[AW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    mean_nxt      = mean_r;
    lowest_nxt    = lowest_r;
    len_nxt       = len_r;
    conf_nxt      = conf_r;
    acc_nxt       = acc_r;
    repl_nxt      = repl_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        sum_nxt = '0;
        min_nxt = crss_pkg::ConfOne;
        found_nxt = 1'b0;
        if (in_valid) begin
          len_nxt  = in_data.new_length;
          conf_nxt = in_data.new_confidence;
          priority if (fill_r < DepthC) begin
            fill_nxt  = fill_r + 1'b1;
            acc_nxt   = 1'b1;
            repl_nxt  = 1'b0;
            state_nxt = ST_PASS;
          end else if (lowest_r < in_data.new_confidence) begin
            acc_nxt   = 1'b1;
            repl_nxt  = 1'b1;
            state_nxt = ST_PASS;
          end else begin
            acc_nxt   = 1'b0;
            repl_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PASS: begin
        if (issue) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r[AW-1:0];
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SW'(eff_len);
          if (eff_conf < min_r) begin
            min_nxt = eff_conf;
          end
        end
        if (hit) begin
          found_nxt = 1'b1;
        end
        if (!issue && !rd_vld_r) begin
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        sum_nxt     = q_step;
        rem_nxt     = qbit ? diff[CW-1:0] : trial[CW-1:0];
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DivLast) begin
          mean_nxt   = q_step[crss_pkg::LenW-1:0];
          lowest_nxt = min_r;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.accepted       = acc_r;
          out_nxt.mean_length    = mean_r;
          out_nxt.low_conf       = lowest_r;
          out_nxt.sample_count   = crss_pkg::CountOutW'(fill_r);
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      mean_r      <= '0;
      lowest_r    <= '0;
      found_r     <= 1'b0;
      repl_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      mean_r      <= mean_nxt;
      lowest_r    <= lowest_nxt;
      found_r     <= found_nxt;
      repl_r      <= repl_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    conf_r    <= conf_nxt;
    acc_r     <= acc_nxt;
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    sum_r     <= sum_nxt;
    min_r     <= min_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_r     <= out_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DepthC)
    else $error("fill count beyond depth");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (fill_r < DepthC)) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("append did not bump the count");

  a_found_mode: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> repl_r)
    else $error("replacement outside replace mode");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (fill_r != '0))
    else $error("divide by zero count");

  a_replace_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PASS) && repl_r && !issue && !rd_vld_r) |-> found_r)
    else $error("no entry at the tracked minimum was replaced");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 8;
  localparam int NUM_DIR = 20;
  localparam int NUM_RAND = 1300;
  localparam int TAIL = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    crss_pkg::in_item_t  d;
    logic                has_exp;
    crss_pkg::out_item_t e;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  crss_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  crss_pkg::out_item_t out_data;

  // model of the store
  logic [15:0] store_len [DEPTH];
  logic [15:0] store_conf [DEPTH];
  int          held;
  logic [15:0] mean_len;
  logic [15:0] floor_conf;

  crss_pkg::out_item_t result_q [$];
  int        mismatches = 0;
  int        quiet = 0;
  bit        idle_en = 0;

  // length, confidence, expectation typed in, accepted, mean, min, count
  stim_row_t dir_rows [NUM_DIR] = '{
    {16'hFFFF, 16'h0000, 1'b1, {1'b1, 16'hFFFF, 16'h0000, 4'd1}},
    {16'hFFFF, 16'h0000, 1'b0, 37'd0},
    {16'hFFFF, 16'h8000, 1'b0, 37'd0},
    {16'hFFFF, 16'hFFFF, 1'b0, 37'd0},
    {16'hFFFF, 16'h0000, 1'b0, 37'd0},
    {16'hFFFF, 16'h0001, 1'b0, 37'd0},
    {16'hFFFF, 16'h00FF, 1'b0, 37'd0},
    {16'hFFFF, 16'hFFFF, 1'b1, {1'b1, 16'hFFFF, 16'h0000, 4'd8}},
    {16'h0000, 16'h0000, 1'b1, {1'b0, 16'hFFFF, 16'h0000, 4'd8}},
    {16'h0000, 16'h0005, 1'b0, 37'd0},
    {16'h1234, 16'h0001, 1'b0, 37'd0},
    {16'h0000, 16'hFFFF, 1'b0, 37'd0},
    {16'hABCD, 16'h0001, 1'b0, 37'd0},
    {16'h5555, 16'h0000, 1'b0, 37'd0},
    {16'hAAAA, 16'h0002, 1'b0, 37'd0},
    {16'h00FF, 16'h0003, 1'b0, 37'd0},
    {16'hFF00, 16'h8001, 1'b0, 37'd0},
    {16'h0001, 16'h0002, 1'b0, 37'd0},
    {16'hFFFF, 16'hFFFE, 1'b0, 37'd0},
    {16'h8000, 16'h7FFF, 1'b0, 37'd0}
  };

  confidence_ranked_sample_store #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic crss_pkg::out_item_t admit_sample(crss_pkg::in_item_t s);
    crss_pkg::out_item_t r;
    logic [31:0] sum;
    logic [15:0] lo;
    bit          take;
    bit          done;
    int          i;
    take = 1'b0;
    done = 1'b0;
    if (held < DEPTH) begin
      store_len[held] = s.new_length;
      store_conf[held] = s.new_confidence;
      held++;
      take = 1'b1;
    end else if (floor_conf < s.new_confidence) begin
      // only the first entry tied at the minimum is replaced
      for (i = 0; i < DEPTH; i++) begin
        if (!done && store_conf[i] == floor_conf) begin
          store_len[i] = s.new_length;
          store_conf[i] = s.new_confidence;
          done = 1'b1;
        end
      end
      take = 1'b1;
    end
    if (take) begin
      sum = 0;
      lo = 16'hFFFF;
      for (i = 0; i < held; i++) begin
        sum += store_len[i];
        if (store_conf[i] < lo) lo = store_conf[i];
      end
      floor_conf = lo;
      mean_len = (held != 0) ? 16'(sum / held) : 16'h0000;
    end
    r.accepted = take;
    r.mean_length = mean_len;
    r.low_conf = floor_conf;
    r.sample_count = 4'(held);
    return r;
  endfunction

  // half the draws give confidences just above the minimum so the store keeps turning over
  function automatic crss_pkg::in_item_t draw_sample();
    crss_pkg::in_item_t s;
    int       pick;
    int       c;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c = int'(floor_conf) + $urandom_range(1, 16);
      if (c > 65535) c = 65535;
    end else if (pick < 65) begin
      c = int'(floor_conf);
    end else if (pick < 78) begin
      c = int'($urandom_range(0, floor_conf));
    end else begin
      c = $urandom_range(0, 65535);
    end
    s.new_confidence = c[15:0];
    pick = $urandom_range(0, 9);
    if (pick == 0) s.new_length = 16'h0000;
    else if (pick == 1) s.new_length = 16'hFFFF;
    else s.new_length = 16'($urandom_range(0, 65535));
    return s;
  endfunction

  initial begin
    crss_pkg::in_item_t  it;
    crss_pkg::out_item_t want;
    int        gap;
    int        n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    held = 0;
    mean_len = 16'h0000;
    floor_conf = 16'h0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (n = 0; n < NUM_DIR + NUM_RAND; n++) begin
      if (n < NUM_DIR) it = dir_rows[n].d;
      else it = draw_sample();
      if (n % 40 == 0)
        idle_en = (n < NUM_DIR + NUM_RAND - TAIL) && ($urandom_range(0, 2) != 0);
      gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clk);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data <= it;
      do @(posedge clk); while (!in_ready);
      want = admit_sample(it);
      if (n < NUM_DIR && dir_rows[n].has_exp) want = dir_rows[n].e;
      result_q.insert(result_q.size(), want);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    crss_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result with no item pending: %p", out_data);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          mismatches++;
        end
        if (out_data.mean_length !== want.mean_length) begin
          $error("mean_length: expected %h, got %h", want.mean_length,
                 out_data.mean_length);
          mismatches++;
        end
        if (out_data.low_conf !== want.low_conf) begin
          $error("low_conf: expected %h, got %h", want.low_conf,
                 out_data.low_conf);
          mismatches++;
        end
        if (out_data.sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count,
                 out_data.sample_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
